// ===== rtl/cwp_pkg.sv =====
// Shared constants, record types and widths for the CAPWAP control message parser.
package cwp_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int OFF_W        = $clog2(16 + MAX_ELEMENTS * 65540 + 1);
   localparam int POS_W        = 17;
   localparam int AREA_W       = 17;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] PH_TRANSPORT = 3'd0;
   localparam logic [2:0] PH_CONTROL   = 3'd1;
   localparam logic [2:0] PH_ELEM_HDR  = 3'd2;
   localparam logic [2:0] PH_VALUE     = 3'd3;
   localparam logic [2:0] PH_FINISHED  = 3'd4;

   localparam logic [2:0] KIND_TRANSPORT = 3'd0;
   localparam logic [2:0] KIND_CONTROL   = 3'd1;
   localparam logic [2:0] KIND_ELEMENT   = 3'd2;
   localparam logic [2:0] KIND_VALUE     = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;
   localparam logic [2:0] KIND_ERROR     = 3'd5;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] code_word;
      logic [15:0] length_word;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic [7:0]  byte_d;
      logic [4:0]  header_len_words;
      logic [3:0]  element_index;
      logic        run_last;
   } rec_type;

   // records caused by one input word
   typedef struct packed {
      logic    two;
      rec_type r0;
      rec_type r1;
   } ent_type;

   typedef struct packed {
      logic    push;
      ent_type ent;
   } grp_type;

endpackage

// ===== rtl/capwap_control_message_parser_unit.sv =====
// CAPWAP control message parser: one byte per word in, header/element/value records out.
// Each record is written to the result queue as its byte is accepted, then offered from it.
// Throughput: one byte per cycle while req_ready is high; a record-bearing last byte of a
// message yields two records, sent in turn from one entry of the four-entry result queue.
// Ready drops only when the result queue has room for fewer than two entries.
// Reset is synchronous, active high: parse state returns to the transport header, queue empties.
module capwap_control_message_parser_unit
   import cwp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_record_kind,
   output logic [31:0] rsp_code_word,
   output logic [15:0] rsp_length_word,
   output logic [7:0]  rsp_byte_a,
   output logic [7:0]  rsp_byte_b,
   output logic [7:0]  rsp_byte_c,
   output logic [7:0]  rsp_byte_d,
   output logic [4:0]  rsp_header_len_words,
   output logic [3:0]  rsp_element_index,
   output logic        rsp_run_last
);

   grp_type grp;
   rec_type rec;
   logic    has_room;

   assign req_ready = has_room;

   cwp_parser_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_valid && has_room),
      .data_byte (req_data_byte),
      .is_last   (req_is_last),
      .grp       (grp)
   );

   cwp_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (grp),
      .has_room (has_room),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_rec   (rec)
   );

   assign rsp_record_kind      = rec.record_kind;
   assign rsp_code_word        = rec.code_word;
   assign rsp_length_word      = rec.length_word;
   assign rsp_byte_a           = rec.byte_a;
   assign rsp_byte_b           = rec.byte_b;
   assign rsp_byte_c           = rec.byte_c;
   assign rsp_byte_d           = rec.byte_d;
   assign rsp_header_len_words = rec.header_len_words;
   assign rsp_element_index    = rec.element_index;
   assign rsp_run_last         = rec.run_last;

endmodule

// ===== rtl/cwp_parser_core.sv =====
// Parse state and record generation, one message byte per accepted word.
module cwp_parser_core
   import cwp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       is_last,
   output grp_type    grp
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [2:0]        phase_ff, phase_in;
   logic [55:0]       hdr_ff, hdr_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       left_ff, left_in;
   logic [31:0]       ehdr_ff, ehdr_in;

   logic [63:0]       h;
   logic [15:0]       alen;
   logic [POS_W:0]    msg_len;
   logic              have0;
   logic              err;
   rec_type           r0, r1, fin;

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      off_in   = off_ff;
      area_in  = area_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      ehdr_in  = ehdr_ff;
      h        = {hdr_ff, data_byte};
      alen     = h[23:8];
      msg_len  = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
      have0    = 1'b0;
      r0       = '0;
      r1       = '0;
      fin      = '0;
      err      = 1'b0;

      case (phase_ff)
         PH_TRANSPORT: begin
            hdr_in = h[55:0];
            if (pos_ff == POS_W'(7)) begin
               have0               = 1'b1;
               r0.record_kind      = KIND_TRANSPORT;
               r0.code_word        = {16'd0, h[23:8]};
               r0.length_word      = {3'd0, h[4:0], 8'd0};
               r0.byte_a           = h[63:56];
               r0.byte_b           = h[47:40];
               r0.byte_c           = h[39:32];
               r0.byte_d           = h[31:24];
               r0.header_len_words = h[55:51];
               phase_in            = PH_CONTROL;
            end
         end
         PH_CONTROL: begin
            hdr_in = h[55:0];
            if (pos_ff == POS_W'(15)) begin
               have0          = 1'b1;
               r0.record_kind = KIND_CONTROL;
               r0.code_word   = h[63:32];
               r0.length_word = alen;
               r0.byte_a      = h[31:24];
               r0.byte_b      = h[7:0];
               area_in        = AREA_W'(13) + {1'b0, alen};
               off_in         = OFF_W'(16);
               cnt_in         = '0;
               if (OFF_W'(16) < OFF_W'(area_in)) begin
                  phase_in = PH_ELEM_HDR;
                  left_in  = 16'd4;
               end else begin
                  phase_in = PH_FINISHED;
               end
            end
         end
         PH_ELEM_HDR: begin
            ehdr_in = {ehdr_ff[23:0], data_byte};
            off_in  = off_ff + OFF_W'(1);
            left_in = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               have0             = 1'b1;
               r0.record_kind    = KIND_ELEMENT;
               r0.code_word      = {16'd0, ehdr_in[31:16]};
               r0.length_word    = ehdr_in[15:0];
               r0.element_index  = 4'(cnt_ff);
               if (ehdr_in[15:0] == 16'd0) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (off_in < OFF_W'(area_ff) && cnt_in < CNT_W'(MAX_ELEMENTS)) begin
                     phase_in = PH_ELEM_HDR;
                     left_in  = 16'd4;
                  end else begin
                     phase_in = PH_FINISHED;
                  end
               end else begin
                  left_in  = ehdr_in[15:0];
                  phase_in = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            have0            = 1'b1;
            r0.record_kind   = KIND_VALUE;
            r0.byte_a        = data_byte;
            r0.element_index = 4'(cnt_ff);
            off_in           = off_ff + OFF_W'(1);
            left_in          = left_ff - 16'd1;
            if (left_in == 16'd0) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (off_in < OFF_W'(area_ff) && cnt_in < CNT_W'(MAX_ELEMENTS)) begin
                  phase_in = PH_ELEM_HDR;
                  left_in  = 16'd4;
               end else begin
                  phase_in = PH_FINISHED;
               end
            end
         end
         default: begin
         end
      endcase

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
      end

      if (is_last) begin
         err = (phase_in != PH_FINISHED) || ({1'b0, area_in} > msg_len);
         if (err) begin
            fin.record_kind = KIND_ERROR;
         end else begin
            fin.record_kind = KIND_DONE;
            fin.code_word   = 32'(off_in);
         end
         fin.run_last = 1'b1;
         if (have0) begin
            r1 = fin;
         end else begin
            r0 = fin;
         end
         pos_in   = '0;
         phase_in = PH_TRANSPORT;
         off_in   = '0;
         area_in  = '0;
         cnt_in   = '0;
         left_in  = '0;
      end else begin
         r0.run_last = 1'b1;
      end

      grp.push    = accept && (have0 || is_last);
      grp.ent.two = have0 && is_last;
      grp.ent.r0  = r0;
      grp.ent.r1  = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_TRANSPORT;
         off_ff   <= '0;
         area_ff  <= '0;
         cnt_ff   <= '0;
         left_ff  <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         off_ff   <= off_in;
         area_ff  <= area_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff  <= hdr_in;
         ehdr_ff <= ehdr_in;
      end
   end

endmodule

// ===== rtl/cwp_result_queue.sv =====
// Small result queue; each entry holds the one or two records of one byte.
module cwp_result_queue
   import cwp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  grp_type wr,
   output logic    has_room,
   output logic    rd_valid,
   input  logic    rd_ready,
   output rec_type rd_rec
);

   ent_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              sub_ff;
   ent_type           head;
   logic              pop;

   assign head     = mem_ff[rd_ptr_ff];
   assign rd_valid = count_ff != '0;
   assign rd_rec   = sub_ff ? head.r1 : head.r0;
   assign pop      = rd_valid && rd_ready && (!head.two || sub_ff);
   assign has_room = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

   always_comb begin
      count_in = count_ff;
      if (wr.push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (!wr.push && pop) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (wr.push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
            sub_ff    <= 1'b0;
         end else if (rd_valid && rd_ready) begin
            sub_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.ent;
      end
   end

endmodule

// ===== dv/capwap_control_message_parser_unit_test.sv =====
// Testbench for the CAPWAP control message parser: header/element/value and done/error record prediction.
`timescale 1ns / 1ps

module capwap_control_message_parser_unit_test
   import cwp_pkg::*;
();

   localparam int CYCLE_LIMIT  = 300000;
   localparam int TARGET_WORDS = 1900;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_record_kind;
   logic [31:0] rsp_code_word;
   logic [15:0] rsp_length_word;
   logic [7:0]  rsp_byte_a;
   logic [7:0]  rsp_byte_b;
   logic [7:0]  rsp_byte_c;
   logic [7:0]  rsp_byte_d;
   logic [4:0]  rsp_header_len_words;
   logic [3:0]  rsp_element_index;
   logic        rsp_run_last;

   capwap_control_message_parser_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_is_last          (req_is_last),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_code_word        (rsp_code_word),
      .rsp_length_word      (rsp_length_word),
      .rsp_byte_a           (rsp_byte_a),
      .rsp_byte_b           (rsp_byte_b),
      .rsp_byte_c           (rsp_byte_c),
      .rsp_byte_d           (rsp_byte_d),
      .rsp_header_len_words (rsp_header_len_words),
      .rsp_element_index    (rsp_element_index),
      .rsp_run_last         (rsp_run_last)
   );

   always #5 clock = ~clock;

   byte_word_type byte_words[$];
   byte_word_type next_word;
   rec_type       pending_records[$];

   int error_count = 0;
   int words_accepted = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_used = 1'b0;
   int msgs_done = 0;
   int msgs_err = 0;
   int elem_headers = 0;
   int value_bytes = 0;

   // parser state
   logic [16:0] pos;
   logic [2:0]  phase;
   logic [63:0] hdr_sh;
   logic [16:0] area_lim;
   logic [4:0]  elem_cnt;
   logic [15:0] bytes_left;
   logic [31:0] elem_sh;

   function automatic void clear_parser();
      pos        = '0;
      phase      = PH_TRANSPORT;
      hdr_sh     = '0;
      area_lim   = '0;
      elem_cnt   = '0;
      bytes_left = '0;
      elem_sh    = '0;
   endfunction

   function automatic void start_element_or_stop();
      if (hdr_sh < 64'(area_lim) && elem_cnt < MAX_ELEMENTS) begin
         phase      = PH_ELEM_HDR;
         bytes_left = 16'd4;
         elem_sh    = '0;
      end else begin
         phase = PH_FINISHED;
      end
   endfunction

   function automatic rec_type make_rec(logic [2:0] kind, logic [31:0] code, logic [15:0] len,
                                        logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                        logic [7:0] d, logic [4:0] hl, logic [3:0] idx);
      rec_type r;
      r.record_kind      = kind;
      r.code_word        = code;
      r.length_word      = len;
      r.byte_a           = a;
      r.byte_b           = b;
      r.byte_c           = c;
      r.byte_d           = d;
      r.header_len_words = hl;
      r.element_index    = idx;
      r.run_last         = 1'b0;
      return r;
   endfunction

   task automatic parse_byte(input logic [7:0] db, input logic last);
      rec_type     recs[$];
      logic [31:0] msg_len;
      logic [15:0] alen;
      logic [15:0] elen;
      bit          bad;
      msg_len = 32'(pos) + 32'd1;
      case (phase)
         PH_TRANSPORT: begin
            hdr_sh = {hdr_sh[55:0], db};
            if (pos == 17'd7) begin
               recs.push_back(make_rec(KIND_TRANSPORT, {16'h0, hdr_sh[23:8]},
                                       {3'b0, hdr_sh[4:0], 8'h00}, hdr_sh[63:56],
                                       hdr_sh[47:40], hdr_sh[39:32], hdr_sh[31:24],
                                       hdr_sh[55:51], 4'd0));
               hdr_sh = '0;
               phase  = PH_CONTROL;
            end
         end
         PH_CONTROL: begin
            hdr_sh = {hdr_sh[55:0], db};
            if (pos == 17'd15) begin
               alen = hdr_sh[23:8];
               recs.push_back(make_rec(KIND_CONTROL, hdr_sh[63:32], alen, hdr_sh[31:24],
                                       hdr_sh[7:0], 8'h00, 8'h00, 5'd0, 4'd0));
               area_lim = 17'd13 + 17'(alen);
               hdr_sh   = 64'd16;
               elem_cnt = '0;
               start_element_or_stop();
            end
         end
         PH_ELEM_HDR: begin
            elem_sh    = {elem_sh[23:0], db};
            hdr_sh     = hdr_sh + 64'd1;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
               elen = elem_sh[15:0];
               recs.push_back(make_rec(KIND_ELEMENT, {16'h0, elem_sh[31:16]}, elen, 8'h00,
                                       8'h00, 8'h00, 8'h00, 5'd0, elem_cnt[3:0]));
               elem_headers++;
               if (elen == 16'd0) begin
                  elem_cnt = elem_cnt + 5'd1;
                  start_element_or_stop();
               end else begin
                  bytes_left = elen;
                  phase      = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            hdr_sh = hdr_sh + 64'd1;
            recs.push_back(make_rec(KIND_VALUE, 32'd0, 16'd0, db, 8'h00, 8'h00, 8'h00,
                                    5'd0, elem_cnt[3:0]));
            value_bytes++;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
               elem_cnt = elem_cnt + 5'd1;
               start_element_or_stop();
            end
         end
         default: ;
      endcase
      if (pos != POS_MAX)
         pos = pos + 17'd1;
      if (last) begin
         bad = (phase != PH_FINISHED) || (32'(area_lim) > msg_len);
         if (bad) begin
            recs.push_back(make_rec(KIND_ERROR, 32'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                                    5'd0, 4'd0));
            msgs_err++;
         end else begin
            recs.push_back(make_rec(KIND_DONE, hdr_sh[31:0], 16'd0, 8'h00, 8'h00, 8'h00,
                                    8'h00, 5'd0, 4'd0));
            msgs_done++;
         end
         clear_parser();
      end
      if (recs.size() != 0)
         recs[recs.size() - 1].run_last = 1'b1;
      foreach (recs[i])
         pending_records.push_back(recs[i]);
   endtask

   task automatic queue_message(input logic [7:0] msg[$]);
      foreach (msg[i])
         byte_words.push_back({msg[i], 1'(i == msg.size() - 1)});
   endtask

   task automatic add_random_message();
      logic [7:0]  msg[$];
      logic [15:0] etype;
      int          style, n_elem, elen, sum, alen, keep;
      style = $urandom_range(0, 99);
      for (int i = 0; i < 13; i++)
         msg.push_back(8'($urandom));
      msg.push_back(8'h00);
      msg.push_back(8'h00);
      msg.push_back(8'($urandom));
      n_elem = (style < 6) ? MAX_ELEMENTS + $urandom_range(1, 3) : $urandom_range(0, 4);
      for (int k = 0; k < n_elem; k++) begin
         etype = 16'($urandom);
         elen  = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         msg.push_back(etype[15:8]);
         msg.push_back(etype[7:0]);
         msg.push_back(8'(elen >> 8));
         msg.push_back(8'(elen));
         for (int j = 0; j < elen; j++)
            msg.push_back(8'($urandom));
      end
      sum = msg.size() - 16;
      if (style >= 6 && style < 16)
         alen = sum + $urandom_range(1, 8);
      else if (style >= 16 && style < 24)
         alen = (sum > 10) ? sum - $urandom_range(1, 10) : 0;
      else if (style >= 24 && style < 29)
         alen = $urandom_range(0, 2);
      else if (style >= 29 && style < 32)
         alen = $urandom_range(0, 65535);
      else
         alen = sum;
      msg[13] = 8'(alen >> 8);
      msg[14] = 8'(alen);
      if ($urandom_range(0, 9) < 3) begin
         repeat ($urandom_range(1, 4))
            msg.push_back(8'($urandom));
      end
      if (style >= 32 && style < 42) begin
         keep = $urandom_range(1, msg.size() - 1);
         msg  = msg[0:keep - 1];
      end
      queue_message(msg);
   endtask

   function automatic bit roll(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic int idle_phase();
      return (words_accepted / 250) % 4;
   endfunction

   function automatic int send_gap_pct();
      case (idle_phase())
         1: return 56;
         3: return 9;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (idle_phase())
         2: return 56;
         3: return 9;
         default: return 0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_record();
      rec_type want;
      if (pending_records.size() == 0) begin
         $display("%0t: unexpected record, expected none, actual kind %0d", $time,
                  rsp_record_kind);
         error_count++;
      end else begin
         want = pending_records.pop_front();
         check_field("record_kind", 32'(want.record_kind), 32'(rsp_record_kind));
         check_field("code_word", want.code_word, rsp_code_word);
         check_field("length_word", 32'(want.length_word), 32'(rsp_length_word));
         check_field("byte_a", 32'(want.byte_a), 32'(rsp_byte_a));
         check_field("byte_b", 32'(want.byte_b), 32'(rsp_byte_b));
         check_field("byte_c", 32'(want.byte_c), 32'(rsp_byte_c));
         check_field("byte_d", 32'(want.byte_d), 32'(rsp_byte_d));
         check_field("header_len_words", 32'(want.header_len_words),
                     32'(rsp_header_len_words));
         check_field("element_index", 32'(want.element_index), 32'(rsp_element_index));
         check_field("run_last", 32'(want.run_last), 32'(rsp_run_last));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, req_is_last);
            words_accepted <= words_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (byte_words.size() != 0 && !roll(send_gap_pct())) begin
               next_word = byte_words.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_word.data;
               req_is_last   <= next_word.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_record();
         rsp_ready <= (hold_left == 0) && !roll(recv_stall_pct());
      end
   end

   // long receiver hold-off so the result queue fills and req_ready drops
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (!hold_used && words_accepted >= 700) begin
         hold_left <= 200;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] msg[$];
      clear_parser();
      // one-byte message, then a truncated header
      msg = '{8'hFF};
      queue_message(msg);
      msg = '{8'h00, 8'h55, 8'hAA};
      queue_message(msg);
      // both headers at extremes, empty element area
      msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
      queue_message(msg);
      while (byte_words.size() < TARGET_WORDS)
         add_random_message();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (byte_words.size() != 0 || req_valid)
         @(posedge clock);
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d messages: %0d completed, %0d ended in error.",
               words_accepted, msgs_done + msgs_err, msgs_done, msgs_err);
      $display("Checked %0d element headers and %0d value bytes.", elem_headers, value_bytes);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== capwap_control_message_parser_unit.f =====
rtl/cwp_pkg.sv
rtl/cwp_parser_core.sv
rtl/cwp_result_queue.sv
rtl/capwap_control_message_parser_unit.sv
dv/capwap_control_message_parser_unit_test.sv
